[rtl/core/rle_mono_blit_to_color_unit_assert.svh]
// Assertion macros used by the blitter pixel engine (rmb_back).
`ifndef RLE_MONO_BLIT_TO_COLOR_UNIT_ASSERT_SVH
`define RLE_MONO_BLIT_TO_COLOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RMB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RMB_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define RMB_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/core/rmb_pkg.sv]
package rmb_pkg;

	localparam int unsigned SCREEN_STRIDE_DEF = 480;
	localparam int unsigned SCREEN_ROWS_DEF   = 320;

	localparam int unsigned COORD_W     = 9;
	localparam int unsigned XY_W        = COORD_W + 1;
	localparam int unsigned LIMIT_W     = XY_W + 1;
	localparam int unsigned POS_W       = 18;
	localparam int unsigned COLOR_W     = 16;
	localparam int unsigned LEN_W       = 8;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned GROUP_SIZE  = 4;
	localparam int unsigned SLOT_W      = 2;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_X       = 3'd0,
		REG_WINDOW_Y       = 3'd1,
		REG_IMAGE_WIDTH    = 3'd2,
		REG_OVERWRITE_MODE = 3'd3,
		REG_LIT_COLOR      = 3'd4,
		REG_DARK_COLOR     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] window_x;
		logic [COORD_W-1:0] window_y;
		logic [COORD_W-1:0] image_width;
		logic               overwrite_mode;
		logic [COLOR_W-1:0] lit_color;
		logic [COLOR_W-1:0] dark_color;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		window_x:       9'd0,
		window_y:       9'd0,
		image_width:    9'd480,
		overwrite_mode: 1'b1,
		lit_color:      16'hFFFF,
		dark_color:     16'h0000
	};

	// one classified run word as queued for the pixel engine
	typedef struct packed {
		logic [LEN_W-1:0] run_length;
		logic             run_on;
		logic             image_start;
	} run_cmd_t;

endpackage

[rtl/core/rmb_if.sv]
interface rmb_in_if;
	logic                      valid;
	logic                      ready;
	logic [rmb_pkg::LEN_W-1:0] run_length;
	logic                      image_start;

	modport source (output valid, output run_length, output image_start, input ready);
	modport sink (input valid, input run_length, input image_start, output ready);
endinterface

interface rmb_out_if;
	logic                        valid;
	logic                        ready;
	logic [rmb_pkg::COLOR_W-1:0] color_a;
	logic [rmb_pkg::COLOR_W-1:0] color_b;
	logic [rmb_pkg::COLOR_W-1:0] color_c;
	logic [rmb_pkg::COLOR_W-1:0] color_d;
	logic [rmb_pkg::CNT_W-1:0]   pixel_count;
	logic [rmb_pkg::POS_W-1:0]   first_pixel_index;
	logic                        last_of_run;

	modport source (output valid, output color_a, output color_b, output color_c,
		output color_d, output pixel_count, output first_pixel_index,
		output last_of_run, input ready);
	modport sink (input valid, input color_a, input color_b, input color_c,
		input color_d, input pixel_count, input first_pixel_index,
		input last_of_run, output ready);
endinterface

interface rmb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rmb_pkg::CFG_INDEX_W-1:0] index;
	logic [rmb_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/rle_mono_blit_to_color_unit.sv]
// Pixel engine: a run of N pixels is issued at most one bitmap access per cycle, unless a
// finished result word waits downstream, on the single-port screen memory; empty runs
// without image start are dropped by the front end and only flip the run parity.
// Reset: a sweep clears all SCREEN_STRIDE*SCREEN_ROWS bitmap entries (153600 at default
// size) with no run words taken; configuration writes are taken throughout.
module rle_mono_blit_to_color_unit #(
	parameter int unsigned SCREEN_STRIDE = rmb_pkg::SCREEN_STRIDE_DEF,
	parameter int unsigned SCREEN_ROWS   = rmb_pkg::SCREEN_ROWS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rmb_in_if.sink    run_in,
	rmb_out_if.source pix_out,
	rmb_cfg_if.sink   cfg
);

	rmb_pkg::cfg_t     cfg_q;
	logic              clearing;
	logic              push_valid;
	logic              push_ready;
	rmb_pkg::run_cmd_t push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	rmb_pkg::run_cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rmb_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			case (rmb_pkg::cfg_reg_t'(cfg.index))
				rmb_pkg::REG_WINDOW_X:       cfg_q.window_x       <= cfg.data[8:0];
				rmb_pkg::REG_WINDOW_Y:       cfg_q.window_y       <= cfg.data[8:0];
				rmb_pkg::REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg.data[8:0];
				rmb_pkg::REG_OVERWRITE_MODE: cfg_q.overwrite_mode <= cfg.data[0];
				rmb_pkg::REG_LIT_COLOR:      cfg_q.lit_color      <= cfg.data;
				rmb_pkg::REG_DARK_COLOR:     cfg_q.dark_color     <= cfg.data;
				default: ;
			endcase
		end
	end

	rmb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.run_in     (run_in),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	rmb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	rmb_back #(
		.SCREEN_STRIDE (SCREEN_STRIDE),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.clearing  (clearing),
		.pix_out   (pix_out)
	);

endmodule

[rtl/core/rmb_fifo.sv]
module rmb_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rmb_pkg::run_cmd_t push_cmd,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rmb_pkg::run_cmd_t pop_cmd
);

	localparam int unsigned DEPTH = rmb_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	rmb_pkg::run_cmd_t entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != CW'(0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/core/rmb_front.sv]
module rmb_front (
	input  logic              clk,
	input  logic              arst_n,
	rmb_in_if.sink            run_in,
	input  logic              clearing,
	output logic              push_valid,
	input  logic              push_ready,
	output rmb_pkg::run_cmd_t push_cmd
);

	logic parity_q;
	logic run_on_c;
	logic drop_c;
	logic accept_c;

	// image start forces an off run and restarts the alternation
	assign run_on_c = !run_in.image_start && parity_q;
	// an empty run that does not start an image only flips the parity
	assign drop_c   = (run_in.run_length == '0) && !run_in.image_start;

	assign run_in.ready = !clearing && (drop_c || push_ready);
	assign push_valid   = run_in.valid && !clearing && !drop_c;
	assign accept_c     = run_in.valid && run_in.ready;

	assign push_cmd.run_length  = run_in.run_length;
	assign push_cmd.run_on      = run_on_c;
	assign push_cmd.image_start = run_in.image_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (accept_c) begin
			parity_q <= !run_on_c;
		end
	end

endmodule

[rtl/core/rmb_back.sv]
module rmb_back #(
	parameter int unsigned SCREEN_STRIDE = rmb_pkg::SCREEN_STRIDE_DEF,
	parameter int unsigned SCREEN_ROWS   = rmb_pkg::SCREEN_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rmb_pkg::cfg_t     cfg_regs,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rmb_pkg::run_cmd_t cmd,
	output logic              clearing,
	rmb_out_if.source         pix_out
);

	`include "rle_mono_blit_to_color_unit_assert.svh"

	localparam int unsigned DEPTH   = SCREEN_STRIDE * SCREEN_ROWS;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned XW      = rmb_pkg::XY_W;
	localparam int unsigned LW      = rmb_pkg::LIMIT_W;
	localparam int unsigned CW      = rmb_pkg::COORD_W;
	localparam int unsigned PSW     = rmb_pkg::POS_W;
	localparam int unsigned SW      = rmb_pkg::SLOT_W;
	localparam int unsigned NW      = rmb_pkg::CNT_W;
	localparam int unsigned HW      = rmb_pkg::COLOR_W;
	localparam int unsigned RW      = rmb_pkg::LEN_W;
	localparam int unsigned GROUP   = rmb_pkg::GROUP_SIZE;
	localparam logic [LW-1:0] STRIDE_L  = LW'(SCREEN_STRIDE);
	localparam logic [LW-1:0] ROWS_L    = LW'(SCREEN_ROWS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	typedef struct packed {
		logic           on;
		logic [SW-1:0]  slot;
		logic           last_grp;
		logic           last_run;
		logic [PSW-1:0] pos;
	} pix_tag_t;

	// bitmap and its clearing sweep
	logic          bitmap_q [DEPTH];
	logic          rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// pixel generator
	logic           busy_q;
	logic [RW-1:0]  rem_q;
	logic           on_q;
	logic [SW-1:0]  slot_q;
	logic [PSW-1:0] pos_q;
	logic [CW-1:0]  col_q;
	logic [CW-1:0]  row_q;

	logic           adv;
	logic           issue;
	logic           pop;
	logic [XW-1:0]  col_next_c;
	logic           col_wrap_c;
	logic           last_run_c;
	logic           last_grp_c;
	logic [XW-1:0]  sx_c;
	logic [XW-1:0]  sy_c;
	pix_tag_t       tag_c;

	// pixel pipeline
	logic          v_s1;
	pix_tag_t      tag_s1;
	logic [XW-1:0] sx_s1;
	logic [XW-1:0] sy_s1;
	logic          ons_c;
	logic [XW+LW-1:0] prod_c;
	logic [AW-1:0] addr_c;

	logic          v_s2;
	pix_tag_t      tag_s2;
	logic [AW-1:0] addr_s2;
	logic          ons_s2;
	logic          wr_c;
	logic          rd_c;

	logic          v_s3;
	pix_tag_t      tag_s3;
	logic          use_rd_s3;
	logic          known_s3;
	logic          bit_c;
	logic [HW-1:0] color_c;

	// result word
	logic           out_valid_q;
	logic [HW-1:0]  color_a_q;
	logic [HW-1:0]  color_b_q;
	logic [HW-1:0]  color_c_q;
	logic [HW-1:0]  color_d_q;
	logic [NW-1:0]  cnt_q;
	logic [PSW-1:0] idx_q;
	logic           lor_q;

	// hold the whole engine while a finished word waits downstream
	assign adv       = !(out_valid_q && !pix_out.ready);
	assign issue     = busy_q && adv;
	assign cmd_ready = !busy_q && !clr_busy_q;
	assign pop       = cmd_valid && cmd_ready;
	assign clearing  = clr_busy_q;

	assign col_next_c = XW'(col_q) + XW'(1);
	assign col_wrap_c = col_next_c >= XW'(cfg_regs.image_width);
	assign last_run_c = rem_q == RW'(1);
	assign last_grp_c = (slot_q == SW'(GROUP - 1)) || last_run_c;
	assign sx_c       = XW'(cfg_regs.window_x) + XW'(col_q);
	assign sy_c       = XW'(cfg_regs.window_y) + XW'(row_q);

	assign tag_c.on       = on_q;
	assign tag_c.slot     = slot_q;
	assign tag_c.last_grp = last_grp_c;
	assign tag_c.last_run = last_run_c;
	assign tag_c.pos      = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			on_q   <= 1'b0;
			slot_q <= '0;
			pos_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (pop) begin
			rem_q  <= cmd.run_length;
			on_q   <= cmd.run_on;
			slot_q <= '0;
			busy_q <= cmd.run_length != '0;
			if (cmd.image_start) begin
				pos_q <= '0;
				col_q <= '0;
				row_q <= '0;
			end
		end else if (issue) begin
			rem_q  <= rem_q - RW'(1);
			busy_q <= !last_run_c;
			slot_q <= last_grp_c ? '0 : slot_q + SW'(1);
			pos_q  <= pos_q + PSW'(1);
			if (col_wrap_c) begin
				col_q <= '0;
				row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_next_c[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign ons_c  = (LW'(sx_s1) < STRIDE_L) && (LW'(sy_s1) < ROWS_L);
	assign prod_c = sy_s1 * STRIDE_L;
	assign addr_c = AW'(prod_c + (XW + LW)'(sx_s1));

	// off pixels in OR mode read back; everything else is known without a read
	assign wr_c = adv && v_s2 && ons_s2 && (tag_s2.on || cfg_regs.overwrite_mode);
	assign rd_c = adv && v_s2 && ons_s2 && !tag_s2.on && !cfg_regs.overwrite_mode;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1    <= tag_c;
			sx_s1     <= sx_c;
			sy_s1     <= sy_c;
			tag_s2    <= tag_s1;
			addr_s2   <= addr_c;
			ons_s2    <= ons_c;
			tag_s3    <= tag_s2;
			use_rd_s3 <= ons_s2 && !tag_s2.on && !cfg_regs.overwrite_mode;
			known_s3  <= ons_s2 && tag_s2.on;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			bitmap_q[clr_addr_q] <= 1'b0;
		end else if (wr_c) begin
			bitmap_q[addr_s2] <= tag_s2.on;
		end
		if (rd_c) begin
			rd_q <= bitmap_q[addr_s2];
		end
	end

	assign bit_c   = use_rd_s3 ? rd_q : known_s3;
	assign color_c = bit_c ? cfg_regs.lit_color : cfg_regs.dark_color;

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			case (tag_s3.slot)
				2'd0: begin
					color_a_q <= color_c;
					color_b_q <= '0;
					color_c_q <= '0;
					color_d_q <= '0;
					idx_q     <= tag_s3.pos;
				end
				2'd1: color_b_q <= color_c;
				2'd2: color_c_q <= color_c;
				default: color_d_q <= color_c;
			endcase
			cnt_q <= NW'(tag_s3.slot) + NW'(1);
			lor_q <= tag_s3.last_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s3 && tag_s3.last_grp) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix_out.valid             = out_valid_q;
	assign pix_out.color_a           = color_a_q;
	assign pix_out.color_b           = color_b_q;
	assign pix_out.color_c           = color_c_q;
	assign pix_out.color_d           = color_d_q;
	assign pix_out.pixel_count       = cnt_q;
	assign pix_out.first_pixel_index = idx_q;
	assign pix_out.last_of_run       = lor_q;

	`RMB_ASSERT_NEVER(a_no_pixels_while_clearing, clk, arst_n, clr_busy_q && (busy_q || v_s1), "pixel issued during bitmap clear")
	`RMB_ASSERT_CLK(a_group_lands_in_word, clk, arst_n, (adv && v_s3 && tag_s3.last_grp) |=> out_valid_q, "finished group not presented")
	`RMB_ASSERT_CLK(a_count_in_range, clk, arst_n, out_valid_q |-> (cnt_q != '0 && cnt_q <= NW'(GROUP)), "pixel count out of range")
	`RMB_ASSERT_CLK(a_stall_holds_pipe, clk, arst_n, (out_valid_q && !pix_out.ready) |=> ($stable(v_s1) && $stable(v_s3)), "engine moved during stall")

endmodule
